/* rtl/ascon_reduced_round_permutation_defines.svh */
// Assertion macros shared by the permutation RTL.
`ifndef ASCON_REDUCED_ROUND_PERMUTATION_DEFINES_SVH
`define ASCON_REDUCED_ROUND_PERMUTATION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ARRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ARRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/arrp_pkg.sv */
// Types and constants of the reduced-round Ascon permutation.
package arrp_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned WORDS    = 5;
  localparam int unsigned RC_W     = 4;
  localparam int unsigned RC_COUNT = 12;
  localparam int unsigned APB_AW   = 3;

  localparam logic [RC_W-1:0] ROUND_COUNT_RESET = 4'd6;

  // Register index codes (paddr[2]).
  localparam logic REG_ROUND_COUNT = 1'b0;

  localparam logic [WORD_W-1:0] ROUND_CONST [RC_COUNT] = '{
    64'h0f00000000000000, 64'h8700000000000000,
    64'h4b00000000000000, 64'hc300000000000000,
    64'h2d00000000000000, 64'ha500000000000000,
    64'h6900000000000000, 64'he100000000000000,
    64'h1e00000000000000, 64'h9600000000000000,
    64'h5a00000000000000, 64'hd200000000000000
  };

  localparam int unsigned ROT_A [WORDS] = '{19, 61, 1, 10, 7};
  localparam int unsigned ROT_B [WORDS] = '{28, 39, 6, 17, 41};

  typedef logic [WORDS-1:0][WORD_W-1:0] state_t;

  typedef struct packed {
    logic [RC_W-1:0] rounds;
    state_t          words;
  } item_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned r);
    rotl = (v << r) | (v >> (WORD_W - r));
  endfunction

endpackage

/* rtl/ascon_reduced_round_permutation.sv */
// Top level of the reduced-round Ascon permutation. A row of MAX_ROUNDS round
// cells, one register stage per round, takes one 320-bit state per clock
// unless stalled, whatever the round count (cells past the count pass the
// state unchanged). Sustained rate is one transaction per cycle while the sink
// is ready; each cell holds its item while the next one is stalled, and empty
// cells take new items, so input keeps flowing into bubbles while a finished
// result waits. round_count is latched per item at input and saturates to
// MAX_ROUNDS; the user writes it only while the block is idle (not enforced).
`include "ascon_reduced_round_permutation_defines.svh"

module ascon_reduced_round_permutation #(
  parameter int unsigned MAX_ROUNDS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [arrp_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // in_word0, in_word1, in_word2, in_word3, in_word4 (64 bits each)
  input  logic [319:0]                s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_word0, out_word1, out_word2, out_word3, out_word4 (64 bits each)
  output logic [319:0]                m_axis_tdata
);

  logic [arrp_pkg::RC_W-1:0] round_count;
  logic [arrp_pkg::RC_W-1:0] rounds_sat;
  logic                      valid_chain [MAX_ROUNDS+1];
  logic                      ready_chain [MAX_ROUNDS+1];
  arrp_pkg::item_t           item_chain  [MAX_ROUNDS+1];

  arrp_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .round_count (round_count)
  );

  assign rounds_sat = (round_count > arrp_pkg::RC_W'(MAX_ROUNDS))
                    ? arrp_pkg::RC_W'(MAX_ROUNDS) : round_count;

  assign valid_chain[0]      = s_axis_tvalid;
  assign s_axis_tready       = ready_chain[0];
  assign item_chain[0].rounds = rounds_sat;
  assign item_chain[0].words  = s_axis_tdata;

  for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_cell
    arrp_round_cell #(
      .IDX        (i),
      .MAX_ROUNDS (MAX_ROUNDS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_chain[i]),
      .in_ready  (ready_chain[i]),
      .in_item   (item_chain[i]),
      .out_valid (valid_chain[i+1]),
      .out_ready (ready_chain[i+1]),
      .out_item  (item_chain[i+1])
    );
  end

  assign m_axis_tvalid           = valid_chain[MAX_ROUNDS];
  assign ready_chain[MAX_ROUNDS] = m_axis_tready;
  assign m_axis_tdata            = item_chain[MAX_ROUNDS].words;

  `ARRP_ASSERT_NEXT(rc_hold_a, !(psel && penable && pwrite),
                    round_count == $past(round_count),
                    "round count changed without a register write")
  `ARRP_ASSERT_NOW(rc_sat_a, 1'b1, rounds_sat <= arrp_pkg::RC_W'(MAX_ROUNDS),
                   "saturated round count above the maximum")
  `ARRP_ASSERT_NOW(ready_a, !s_axis_tready, valid_chain[1],
                   "input stalled while the first cell is empty")

endmodule

/* rtl/arrp_round_cell.sv */
// One Ascon round stage: applies round IDX if the item asks for it, else passes on.
`include "ascon_reduced_round_permutation_defines.svh"

module arrp_round_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned MAX_ROUNDS = 12
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  arrp_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output arrp_pkg::item_t out_item
);

  logic            valid;
  arrp_pkg::item_t item;
  arrp_pkg::item_t item_next;
  arrp_pkg::state_t x;
  arrp_pkg::state_t y;
  logic            apply;

  assign apply = in_item.rounds > arrp_pkg::RC_W'(IDX);

  always_comb begin
    x = in_item.words;
    x[2] = x[2] ^ arrp_pkg::ROUND_CONST[IDX];
    y[0] = (x[4] & x[1]) ^ x[3] ^ (x[2] & x[1]) ^ x[2] ^ (x[1] & x[0]) ^ x[1] ^ x[0];
    y[1] = x[4] ^ (x[3] & x[2]) ^ (x[3] & x[1]) ^ x[3] ^ (x[2] & x[1]) ^ x[2]
         ^ x[1] ^ x[0];
    y[2] = ~((x[4] & x[3]) ^ x[4] ^ x[2] ^ x[1]);
    y[3] = (x[4] & x[0]) ^ x[4] ^ (x[3] & x[0]) ^ x[3] ^ x[2] ^ x[1] ^ x[0];
    y[4] = (x[4] & x[1]) ^ x[4] ^ x[3] ^ (x[1] & x[0]) ^ x[1];
    item_next.rounds = in_item.rounds;
    for (int k = 0; k < arrp_pkg::WORDS; k++) begin
      if (apply) begin
        item_next.words[k] = y[k] ^ arrp_pkg::rotl(y[k], arrp_pkg::ROT_A[k])
                           ^ arrp_pkg::rotl(y[k], arrp_pkg::ROT_B[k]);
      end else begin
        item_next.words[k] = in_item.words[k];
      end
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  `ARRP_ASSERT_NEXT(cell_hold_a, valid && !out_ready, valid && $stable(item),
                    "round cell lost or changed a stalled item")
  `ARRP_ASSERT_NOW(cell_rounds_a, valid, item.rounds <= arrp_pkg::RC_W'(MAX_ROUNDS),
                   "round cell holds a count above the maximum")

endmodule

/* rtl/arrp_apb_regs.sv */
// APB register file holding the round count.
module arrp_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [arrp_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [arrp_pkg::RC_W-1:0]   round_count
);

  logic reg_index;

  assign reg_index = paddr[2];
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= arrp_pkg::ROUND_COUNT_RESET;
    end else if (psel && penable && pwrite && pready
                 && reg_index == arrp_pkg::REG_ROUND_COUNT) begin
      round_count <= pwdata[arrp_pkg::RC_W-1:0];
    end
  end

  always_comb begin
    case (reg_index)
      arrp_pkg::REG_ROUND_COUNT: prdata = {{(32-arrp_pkg::RC_W){1'b0}}, round_count};
      default:                   prdata = '0;
    endcase
  end

endmodule

/* verif/tb_ascon_reduced_round_permutation.sv */
// Self-checking testbench for the reduced-round Ascon permutation stream block.
`timescale 1ns / 1ps

module tb_ascon_reduced_round_permutation;

  localparam int unsigned MAX_ROUNDS = 12;
  localparam int unsigned PHASES     = 10;
  localparam int unsigned PHASE_LEN  = 185;

  localparam logic REG_UNUSED = 1'b1;

  localparam logic [7:0] RC_BYTE [12] = '{
    8'h0f, 8'h87, 8'h4b, 8'hc3, 8'h2d, 8'ha5,
    8'h69, 8'he1, 8'h1e, 8'h96, 8'h5a, 8'hd2
  };
  localparam int unsigned ROT_LO [5] = '{19, 61, 1, 10, 7};
  localparam int unsigned ROT_HI [5] = '{28, 39, 6, 17, 41};

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [arrp_pkg::APB_AW-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  arrp_pkg::state_t            s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [319:0]                m_axis_tdata;

  arrp_pkg::state_t          pending_states[$];
  arrp_pkg::state_t          permuted_q[$];
  logic [arrp_pkg::RC_W-1:0] rounds_cfg = arrp_pkg::ROUND_COUNT_RESET;
  int unsigned               send_idle_pct = 0;
  int unsigned               sink_stall_pct = 0;
  int unsigned               errors = 0;
  int unsigned               results_seen = 0;
  arrp_pkg::state_t          want_state;
  arrp_pkg::state_t          got_state;

  ascon_reduced_round_permutation #(.MAX_ROUNDS(MAX_ROUNDS)) u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [63:0] rot_left(input logic [63:0] v, input int unsigned r);
    logic [127:0] t;
    t = {v, v} << r;
    return t[127:64];
  endfunction

  function automatic arrp_pkg::state_t ascon_rounds(input arrp_pkg::state_t s,
                                                    input int unsigned n);
    logic [63:0] x0, x1, x2, x3, x4;
    logic [63:0] y [5];
    if (n > MAX_ROUNDS) n = MAX_ROUNDS;
    for (int unsigned i = 0; i < n; i++) begin
      s[2] ^= {RC_BYTE[i], 56'h0};
      x0 = s[0]; x1 = s[1]; x2 = s[2]; x3 = s[3]; x4 = s[4];
      y[0] = (x4 & x1) ^ x3 ^ (x2 & x1) ^ x2 ^ (x1 & x0) ^ x1 ^ x0;
      y[1] = x4 ^ (x3 & x2) ^ (x3 & x1) ^ x3 ^ (x2 & x1) ^ x2 ^ x1 ^ x0;
      y[2] = ~((x4 & x3) ^ x4 ^ x2 ^ x1);
      y[3] = (x4 & x0) ^ x4 ^ (x3 & x0) ^ x3 ^ x2 ^ x1 ^ x0;
      y[4] = (x4 & x1) ^ x4 ^ x3 ^ (x1 & x0) ^ x1;
      for (int k = 0; k < 5; k++)
        s[k] = y[k] ^ rot_left(y[k], ROT_LO[k]) ^ rot_left(y[k], ROT_HI[k]);
    end
    return s;
  endfunction

  function automatic logic [63:0] rand_word();
    int unsigned pick;
    logic [63:0] w;
    pick = $urandom_range(99);
    w = {$urandom, $urandom};
    if (pick < 5) w = '0;
    else if (pick < 10) w = '1;
    else if (pick < 15) w = 64'h1 << $urandom_range(63);
    else if (pick < 20) w = w & {$urandom, $urandom} & {$urandom, $urandom};
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int word,
                                 input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s (result %0d word %0d): got %h want %h",
             what, results_seen, word, got, want);
    errors++;
  endtask

  task automatic apb_write(input logic [arrp_pkg::APB_AW-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr[2] == arrp_pkg::REG_ROUND_COUNT) rounds_cfg = data[arrp_pkg::RC_W-1:0];
  endtask

  task automatic apb_check_rounds();
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
    paddr <= {arrp_pkg::REG_ROUND_COUNT, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[arrp_pkg::RC_W-1:0] !== rounds_cfg)
      report_mismatch("round_count readback", 0, 64'(prdata), 64'(rounds_cfg));
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_states.size() != 0 || s_axis_tvalid || permuted_q.size() != 0)
      @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) permuted_q.push_back(ascon_rounds(s_axis_tdata, rounds_cfg));
      if (pending_states.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= pending_states.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_state = m_axis_tdata;
        if (permuted_q.size() == 0) begin
          report_mismatch("unexpected transaction", 0, got_state[0], '0);
        end else begin
          want_state = permuted_q.pop_front();
          for (int k = 0; k < 5; k++)
            if (got_state[k] !== want_state[k])
              report_mismatch("state word", k, got_state[k], want_state[k]);
        end
        results_seen++;
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin : stimulus
    int unsigned      phase_rounds [PHASES];
    arrp_pkg::state_t s;
    phase_rounds = '{1, 12, 15, 0, 13, 2, 14, 7, 12, 1};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    apb_check_rounds();

    // directed: reset round count, then zero rounds
    @(negedge clk);
    pending_states.push_back('0);
    pending_states.push_back('1);
    for (int k = 0; k < 5; k++) begin
      s = '0;
      s[k] = '1;
      pending_states.push_back(s);
    end
    pending_states.push_back({5{64'haaaa_aaaa_aaaa_aaaa}});
    pending_states.push_back({5{64'h5555_5555_5555_5555}});
    pending_states.push_back({5{64'h8000_0000_0000_0001}});
    wait_idle();

    apb_write({arrp_pkg::REG_ROUND_COUNT, 2'b00}, 32'h0);
    apb_check_rounds();
    @(negedge clk);
    pending_states.push_back('1);
    pending_states.push_back({5{64'h0123_4567_89ab_cdef}});
    for (int k = 0; k < 5; k++) pending_states.push_back({rand_word(), rand_word(),
      rand_word(), rand_word(), rand_word()});
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      apb_write({arrp_pkg::REG_ROUND_COUNT, 2'b00},
                {28'($urandom), 4'(phase_rounds[p])});
      if (p == 5) apb_write({REG_UNUSED, 2'b00}, $urandom);
      apb_check_rounds();
      @(negedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 84; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 84; end
        default: begin send_idle_pct = 30; sink_stall_pct = 30; end
      endcase
      for (int n = 0; n < PHASE_LEN; n++)
        pending_states.push_back({rand_word(), rand_word(), rand_word(),
                                  rand_word(), rand_word()});
      wait_idle();
    end

    repeat (4 * MAX_ROUNDS) @(posedge clk);
    if (permuted_q.size() != 0)
      report_mismatch("missing transaction", 0, '0, permuted_q[0][0]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/arrp_pkg.sv
rtl/arrp_round_cell.sv
rtl/arrp_apb_regs.sv
rtl/ascon_reduced_round_permutation.sv
verif/tb_ascon_reduced_round_permutation.sv
